@@ rtl/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants for the radar startup self-test monitor:
// item words, configuration set, state codes and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

    // Field widths fixed by the item and register formats.
    localparam int unsigned SPEED_W   = 16;
    localparam int unsigned SPDMIN_W  = 15;
    localparam int unsigned RANGE_W   = 12;
    localparam int unsigned CONF_W    = 8;
    localparam int unsigned ELAPSED_W = 20;
    localparam int unsigned CYCLE_W   = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 20;

    // Component state codes; every other code means not running.
    localparam logic [1:0] COMP_RUN      = 2'd0;
    localparam logic [1:0] COMP_TEMP_ERR = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SELFTEST_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONF_MIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REACT_RANGE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REACT_CONF      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT_MS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME_MS   = 3'd7;

    // Register reset values.
    localparam logic [ELAPSED_W-1:0] TIME_LIMIT_RST = 20'd120000;
    localparam logic [CYCLE_W-1:0]   CYCLE_TIME_RST = 10'd60;

    // Self-test states.
    typedef enum logic [1:0] {
        ST_STARTUP = 2'd0,
        ST_ON      = 2'd1,
        ST_OFF     = 2'd2
    } t_state;

    // Event codes.
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_INACTIVE = 2'd1,
        EV_ACTIVE   = 2'd2
    } t_event;

    // One measurement cycle word.
    typedef struct packed {
        logic [1:0]                comp_state;
        logic signed [SPEED_W-1:0] ego_speed;
        logic                      bench_active;
        logic [RANGE_W-1:0]        range_moving;
        logic [RANGE_W-1:0]        range_stationary;
        logic [RANGE_W-1:0]        range_stat_max;
        logic [CONF_W-1:0]         conf_moving;
        logic [CONF_W-1:0]         conf_stationary;
    } t_in_item;

    // One result word.
    typedef struct packed {
        logic [1:0] test_state;
        logic [1:0] selftest_event;
        logic [1:0] blockage_event;
        logic [1:0] not_measured_event;
        logic [1:0] not_measured_fail_event;
    } t_out_item;

    // Configuration register set.
    typedef struct packed {
        logic                 selftest_enable;
        logic [SPDMIN_W-1:0]  speed_min;
        logic [RANGE_W-1:0]   range_min;
        logic [CONF_W-1:0]    conf_min;
        logic [RANGE_W-1:0]   react_range;
        logic [CONF_W-1:0]    react_conf;
        logic [ELAPSED_W-1:0] time_limit_ms;
        logic [CYCLE_W-1:0]   cycle_time_ms;
    } t_cfg;

    // Self-test state carried from one word to the next.
    typedef struct packed {
        t_state               cur;
        t_state               last;
        logic [ELAPSED_W-1:0] elapsed;
    } t_test_regs;

endpackage

`default_nettype wire

@@ rtl/ssm_eval.sv @@
// ----------------------------------------------------------------------------
// ssm_eval
// Evaluates one measurement word against the self-test state: pass criteria,
// time-out counting, state transitions and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_eval (
    input  wire ssm_pkg::t_cfg       i_cfg,
    input  wire ssm_pkg::t_in_item   i_item,
    input  wire ssm_pkg::t_test_regs i_regs,
    output ssm_pkg::t_test_regs      o_regs,
    output ssm_pkg::t_out_item       o_res
);

    logic                             spd_ok;
    logic                             bypass;
    logic                             weak_ok;
    logic                             strong_ok;
    logic                             w_mov_ok;
    logic                             w_c1;
    logic                             w_c2;
    logic                             w_c3;
    logic                             s_mov_ok;
    logic                             s_c1;
    logic                             s_c2;
    logic                             s_c3;
    logic [ssm_pkg::CONF_W:0]         conf_x2;
    logic [ssm_pkg::CONF_W+1:0]       conf_x4;
    logic [ssm_pkg::ELAPSED_W:0]      time_sum;
    logic [ssm_pkg::ELAPSED_W-1:0]    time_sat;
    ssm_pkg::t_event                  ev_st;
    ssm_pkg::t_event                  ev_bl;
    ssm_pkg::t_event                  ev_nm;
    ssm_pkg::t_event                  ev_nf;

    // Speed gate: a negative speed never exceeds the unsigned minimum.
    assign spd_ok = !i_item.ego_speed[ssm_pkg::SPEED_W-1]
                  && (i_item.ego_speed[ssm_pkg::SPEED_W-2:0] > i_cfg.speed_min);
    assign bypass = !i_cfg.selftest_enable || i_item.bench_active;

    // Doubled and quadrupled stationary confidence thresholds.
    assign conf_x2 = {i_cfg.conf_min, 1'b0};
    assign conf_x4 = {i_cfg.conf_min, 2'b00};

    // Weak activation criteria used in startup.
    assign w_mov_ok = (i_item.range_moving > i_cfg.range_min)
                   || (i_item.conf_moving < i_cfg.conf_min);
    assign w_c1 = (i_item.range_moving > i_cfg.range_min)
               && (i_item.conf_moving > i_cfg.conf_min)
               && ((i_item.range_stationary > i_cfg.range_min)
                   || (i_item.conf_stationary < i_cfg.conf_min));
    assign w_c2 = (i_item.range_stationary > i_cfg.range_min)
               && ({1'b0, i_item.conf_stationary} > conf_x2) && w_mov_ok;
    assign w_c3 = (i_item.range_stat_max > i_cfg.react_range)
               && ({2'b00, i_item.conf_stationary} > conf_x4) && w_mov_ok;
    assign weak_ok = w_c1 || w_c2 || w_c3;

    // Stronger reactivation criteria used in off.
    assign s_mov_ok = (i_item.range_moving > i_cfg.react_range)
                   || (i_item.conf_moving < i_cfg.react_conf);
    assign s_c1 = (i_item.range_moving > i_cfg.react_range)
               && (i_item.conf_moving > i_cfg.react_conf)
               && ((i_item.range_stationary > i_cfg.react_range)
                   || (i_item.conf_stationary < i_cfg.react_conf));
    assign s_c2 = (i_item.range_stationary > i_cfg.react_range)
               && (i_item.conf_stationary > i_cfg.react_conf) && s_mov_ok;
    assign s_c3 = (i_item.range_stat_max > i_cfg.react_range)
               && (i_item.conf_stationary > i_cfg.react_conf) && s_mov_ok;
    assign strong_ok = s_c1 || s_c2 || s_c3;

    // Millisecond counter advance, saturating at full scale.
    assign time_sum = {1'b0, i_regs.elapsed}
                    + {{(ssm_pkg::ELAPSED_W+1-ssm_pkg::CYCLE_W){1'b0}}, i_cfg.cycle_time_ms};
    assign time_sat = time_sum[ssm_pkg::ELAPSED_W] ? '1 : time_sum[ssm_pkg::ELAPSED_W-1:0];

    // State transition and event selection.
    always_comb begin
        o_regs = i_regs;
        ev_st  = ssm_pkg::EV_NONE;
        ev_bl  = ssm_pkg::EV_NONE;
        ev_nm  = ssm_pkg::EV_NONE;
        ev_nf  = ssm_pkg::EV_NONE;
        case (i_item.comp_state)
            ssm_pkg::COMP_TEMP_ERR: begin
                ev_st = ssm_pkg::EV_INACTIVE;
                ev_bl = ssm_pkg::EV_INACTIVE;
                ev_nm = ssm_pkg::EV_INACTIVE;
                ev_nf = ssm_pkg::EV_INACTIVE;
            end
            ssm_pkg::COMP_RUN: begin
                if (bypass) begin
                    o_regs.cur = ssm_pkg::ST_ON;
                end else begin
                    o_regs.cur = i_regs.last;
                    if (spd_ok) begin
                        unique case (i_regs.last)
                            ssm_pkg::ST_STARTUP: begin
                                if (weak_ok) begin
                                    o_regs.cur  = ssm_pkg::ST_ON;
                                    o_regs.last = ssm_pkg::ST_ON;
                                end else if (i_regs.elapsed > i_cfg.time_limit_ms) begin
                                    o_regs.cur  = ssm_pkg::ST_OFF;
                                    o_regs.last = ssm_pkg::ST_OFF;
                                end else begin
                                    o_regs.elapsed = time_sat;
                                end
                            end
                            ssm_pkg::ST_OFF: begin
                                if (strong_ok) begin
                                    o_regs.cur  = ssm_pkg::ST_ON;
                                    o_regs.last = ssm_pkg::ST_ON;
                                end else begin
                                    o_regs.elapsed = time_sat;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // Events follow the state after this word.
                unique case (o_regs.cur)
                    ssm_pkg::ST_STARTUP: begin
                        ev_st = ssm_pkg::EV_ACTIVE;
                        ev_bl = ssm_pkg::EV_INACTIVE;
                        ev_nm = ssm_pkg::EV_ACTIVE;
                    end
                    ssm_pkg::ST_ON: begin
                        ev_st = ssm_pkg::EV_INACTIVE;
                        ev_nm = ssm_pkg::EV_INACTIVE;
                        ev_nf = ssm_pkg::EV_INACTIVE;
                    end
                    ssm_pkg::ST_OFF: begin
                        ev_st = ssm_pkg::EV_ACTIVE;
                        ev_bl = ssm_pkg::EV_ACTIVE;
                        ev_nm = ssm_pkg::EV_ACTIVE;
                        ev_nf = ssm_pkg::EV_ACTIVE;
                    end
                    default: begin
                        ev_st = ssm_pkg::EV_ACTIVE;
                        ev_bl = ssm_pkg::EV_ACTIVE;
                    end
                endcase
            end
            default: begin
                // Component not running: state held, all events left at none.
            end
        endcase
    end

    // Result word.
    assign o_res.test_state              = o_regs.cur;
    assign o_res.selftest_event          = ev_st;
    assign o_res.blockage_event          = ev_bl;
    assign o_res.not_measured_event      = ev_nm;
    assign o_res.not_measured_fail_event = ev_nf;

endmodule

`default_nettype wire

@@ rtl/sensor_selftest_monitor_core.sv @@
// ----------------------------------------------------------------------------
// sensor_selftest_monitor_core
// Radar startup self-test monitor: one measurement word in, one status word
// with test state and four event codes out.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on i_in_valid / o_in_stall / i_in_data and are taken
//   at an edge with valid high and stall low. Each word yields exactly one
//   result word on o_out_valid / i_out_stall / o_out_data.
//   A word is first captured in the input register; it is then evaluated
//   against the self-test state and the result register is loaded once that
//   register is empty or its word is being taken by the receiver.
//   One word is taken per clock while the receiver does not stall. The state
//   feedback loop (criteria compare, counter add and state update) closes
//   through the self-test state register, loaded with the result register.
//   When the receiver stalls, the result register holds its word; o_in_stall
//   rises once the input register is full. Reset clears both stages, puts
//   the test in startup with a zero counter and loads the register defaults.
//   Registers are written on i_cfg_we with i_cfg_idx selecting the register;
//   the user must write only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_selftest_monitor_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write port.
    input  wire                                i_cfg_we,
    input  wire [ssm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [ssm_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    // Measurement words.
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire ssm_pkg::t_in_item             i_in_data,
    // Result words.
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output ssm_pkg::t_out_item                 o_out_data
);

    ssm_pkg::t_cfg       r_cfg;
    ssm_pkg::t_test_regs r_regs;
    ssm_pkg::t_test_regs n_regs;
    logic                r_in_valid;
    ssm_pkg::t_in_item   r_in;
    logic                r_out_valid;
    ssm_pkg::t_out_item  r_out;
    ssm_pkg::t_out_item  n_out;
    logic                advance;
    logic                in_take;

    // Pipeline flow control.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.selftest_enable <= 1'b1;
            r_cfg.speed_min       <= '0;
            r_cfg.range_min       <= '0;
            r_cfg.conf_min        <= '0;
            r_cfg.react_range     <= '0;
            r_cfg.react_conf      <= '0;
            r_cfg.time_limit_ms   <= ssm_pkg::TIME_LIMIT_RST;
            r_cfg.cycle_time_ms   <= ssm_pkg::CYCLE_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssm_pkg::REG_SELFTEST_ENABLE: r_cfg.selftest_enable <= i_cfg_data[0];
                ssm_pkg::REG_SPEED_MIN:
                    r_cfg.speed_min <= i_cfg_data[ssm_pkg::SPDMIN_W-1:0];
                ssm_pkg::REG_RANGE_MIN:
                    r_cfg.range_min <= i_cfg_data[ssm_pkg::RANGE_W-1:0];
                ssm_pkg::REG_CONF_MIN:
                    r_cfg.conf_min <= i_cfg_data[ssm_pkg::CONF_W-1:0];
                ssm_pkg::REG_REACT_RANGE:
                    r_cfg.react_range <= i_cfg_data[ssm_pkg::RANGE_W-1:0];
                ssm_pkg::REG_REACT_CONF:
                    r_cfg.react_conf <= i_cfg_data[ssm_pkg::CONF_W-1:0];
                ssm_pkg::REG_TIME_LIMIT_MS:
                    r_cfg.time_limit_ms <= i_cfg_data[ssm_pkg::ELAPSED_W-1:0];
                ssm_pkg::REG_CYCLE_TIME_MS:
                    r_cfg.cycle_time_ms <= i_cfg_data[ssm_pkg::CYCLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Evaluation of the registered word.
    ssm_eval u_eval (
        .i_cfg  (r_cfg),
        .i_item (r_in),
        .i_regs (r_regs),
        .o_regs (n_regs),
        .o_res  (n_out)
    );

    // Self-test state, updated once per evaluated word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.cur     <= ssm_pkg::ST_STARTUP;
            r_regs.last    <= ssm_pkg::ST_STARTUP;
            r_regs.elapsed <= '0;
        end else if (r_in_valid && advance) begin
            r_regs <= n_regs;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ test/tb_sensor_selftest_monitor_core.sv @@
// ----------------------------------------------------------------------------
// tb_sensor_selftest_monitor_core
// Drives measurement words through the self-test monitor under several
// register settings and checks every status word against a word-by-word
// prediction of the test state and event codes, with a model of the counter.
// ----------------------------------------------------------------------------
module tb_sensor_selftest_monitor_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 250000;
    localparam logic [ssm_pkg::RANGE_W-1:0]   RANGE_MAX   = '1;
    localparam logic [ssm_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;
    // Component codes that the block treats as not running.
    localparam logic [1:0] COMP_IDLE  = 2'd2;
    localparam logic [1:0] COMP_UNDEF = 2'd3;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_cfg_we   = 1'b0;
    logic [ssm_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [ssm_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    ssm_pkg::t_in_item             i_in_data  = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    ssm_pkg::t_out_item            o_out_data;

    // Shadow of the register set and of the self-test state.
    ssm_pkg::t_cfg       cfg;
    ssm_pkg::t_test_regs tst;

    ssm_pkg::t_in_item   meas_pending[$];
    ssm_pkg::t_out_item  status_expected[$];
    int unsigned words_queued  = 0;
    int unsigned words_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned error_count   = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count   = 0;
    bit          exit_by_pass;

    // Driver and monitor scratch state.
    bit          word_taken;
    bit          in_gaps_on    = 1'b1;
    int unsigned in_gap_left   = 0;
    bit          out_stalls_on = 1'b1;
    int unsigned stall_left    = 0;

    sensor_selftest_monitor_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predict the status word for one accepted measurement word and advance the state.
    function automatic ssm_pkg::t_out_item predict_status(input ssm_pkg::t_in_item w);
        ssm_pkg::t_out_item r;
        int          spd;
        int unsigned rm, rs, rx, cm, cs, rmin, cmin, rr, rc, sum;
        bit          mov_weak, mov_strong, weak_ok, strong_ok, add_ms;
        r      = '0;
        add_ms = 1'b0;
        spd    = $signed(w.ego_speed);
        rm     = w.range_moving;
        rs     = w.range_stationary;
        rx     = w.range_stat_max;
        cm     = w.conf_moving;
        cs     = w.conf_stationary;
        rmin   = cfg.range_min;
        cmin   = cfg.conf_min;
        rr     = cfg.react_range;
        rc     = cfg.react_conf;

        // Startup criteria: the stationary confidence bar is doubled and quadrupled.
        mov_weak = (rm > rmin) || (cm < cmin);
        weak_ok  = ((rm > rmin) && (cm > cmin) && ((rs > rmin) || (cs < cmin)))
                || ((rs > rmin) && (cs > 2 * cmin) && mov_weak)
                || ((rx > rr) && (cs > 4 * cmin) && mov_weak);
        // Reactivation criteria out of the failed state.
        mov_strong = (rm > rr) || (cm < rc);
        strong_ok  = ((rm > rr) && (cm > rc) && ((rs > rr) || (cs < rc)))
                  || ((rs > rr) && (cs > rc) && mov_strong)
                  || ((rx > rr) && (cs > rc) && mov_strong);

        if (w.comp_state == ssm_pkg::COMP_TEMP_ERR) begin
            r.selftest_event          = ssm_pkg::EV_INACTIVE;
            r.blockage_event          = ssm_pkg::EV_INACTIVE;
            r.not_measured_event      = ssm_pkg::EV_INACTIVE;
            r.not_measured_fail_event = ssm_pkg::EV_INACTIVE;
        end else if (w.comp_state == ssm_pkg::COMP_RUN) begin
            if (!cfg.selftest_enable || w.bench_active) begin
                tst.cur = ssm_pkg::ST_ON;
            end else if (spd > int'(cfg.speed_min)) begin
                tst.cur = tst.last;
                if (tst.cur == ssm_pkg::ST_STARTUP) begin
                    if (weak_ok) begin
                        tst.cur  = ssm_pkg::ST_ON;
                        tst.last = ssm_pkg::ST_ON;
                    end else if (tst.elapsed > cfg.time_limit_ms) begin
                        tst.cur  = ssm_pkg::ST_OFF;
                        tst.last = ssm_pkg::ST_OFF;
                    end else begin
                        add_ms = 1'b1;
                    end
                end else if (tst.cur == ssm_pkg::ST_OFF) begin
                    if (strong_ok) begin
                        tst.cur  = ssm_pkg::ST_ON;
                        tst.last = ssm_pkg::ST_ON;
                    end else begin
                        add_ms = 1'b1;
                    end
                end
            end else begin
                tst.cur = tst.last;
            end

            // The counter saturates instead of wrapping.
            if (add_ms) begin
                sum = tst.elapsed + cfg.cycle_time_ms;
                tst.elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX
                                                  : ssm_pkg::ELAPSED_W'(sum);
            end

            case (tst.cur)
                ssm_pkg::ST_STARTUP: begin
                    r.selftest_event     = ssm_pkg::EV_ACTIVE;
                    r.blockage_event     = ssm_pkg::EV_INACTIVE;
                    r.not_measured_event = ssm_pkg::EV_ACTIVE;
                end
                ssm_pkg::ST_ON: begin
                    r.selftest_event          = ssm_pkg::EV_INACTIVE;
                    r.not_measured_event      = ssm_pkg::EV_INACTIVE;
                    r.not_measured_fail_event = ssm_pkg::EV_INACTIVE;
                end
                default: begin
                    r.selftest_event          = ssm_pkg::EV_ACTIVE;
                    r.blockage_event          = ssm_pkg::EV_ACTIVE;
                    r.not_measured_event      = ssm_pkg::EV_ACTIVE;
                    r.not_measured_fail_event = ssm_pkg::EV_ACTIVE;
                end
            endcase
        end
        r.test_state = tst.cur;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [1:0] got,
                               input logic [1:0] want);
        if (got !== want)
            report($sformatf("status word %0d: %s is %0d, expected %0d",
                             results_seen, name, got, want));
    endtask

    // Compare one status word with the oldest prediction.
    task automatic check_status(input ssm_pkg::t_out_item got);
        ssm_pkg::t_out_item want;
        if (status_expected.size() == 0) begin
            report($sformatf("status word %0d arrived with nothing pending", results_seen));
        end else begin
            want = status_expected.pop_front();
            check_field("test_state", got.test_state, want.test_state);
            check_field("selftest_event", got.selftest_event, want.selftest_event);
            check_field("blockage_event", got.blockage_event, want.blockage_event);
            check_field("not_measured_event", got.not_measured_event,
                        want.not_measured_event);
            check_field("not_measured_fail_event", got.not_measured_fail_event,
                        want.not_measured_fail_event);
        end
        results_seen++;
    endtask

    // Input driver: one word from the pending queue, with a random gap after each word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            in_gap_left = 0;
        end else begin
            word_taken = i_in_valid && !o_in_stall;
            if (word_taken) begin
                status_expected.push_back(predict_status(i_in_data));
                words_taken++;
                in_gap_left = in_gaps_on ? $urandom_range(0, 3) : 0;
                if ($urandom_range(0, 49) == 0)
                    in_gaps_on = !in_gaps_on;
            end
            if (!i_in_valid || word_taken) begin
                if (in_gap_left != 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (meas_pending.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= meas_pending.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted word, then stall for a random count.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_status(o_out_data);
                stall_left = out_stalls_on ? $urandom_range(0, 3) : 0;
                if ($urandom_range(0, 49) == 0)
                    out_stalls_on = !out_stalls_on;
            end else if (stall_left != 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic ssm_pkg::t_in_item mk(input logic [1:0] comp, input int spd,
                                             input bit bench,
                                             input int unsigned rm, input int unsigned rs,
                                             input int unsigned rx, input int unsigned cm,
                                             input int unsigned cs);
        ssm_pkg::t_in_item w;
        w.comp_state       = comp;
        w.ego_speed        = ssm_pkg::SPEED_W'(spd);
        w.bench_active     = bench;
        w.range_moving     = ssm_pkg::RANGE_W'(rm);
        w.range_stationary = ssm_pkg::RANGE_W'(rs);
        w.range_stat_max   = ssm_pkg::RANGE_W'(rx);
        w.conf_moving      = ssm_pkg::CONF_W'(cm);
        w.conf_stationary  = ssm_pkg::CONF_W'(cs);
        return w;
    endfunction

    // Range close to one of the active range thresholds, or anywhere.
    function automatic logic [ssm_pkg::RANGE_W-1:0] pick_range();
        int unsigned thr;
        thr = $urandom_range(0, 1) ? cfg.range_min : cfg.react_range;
        case ($urandom_range(0, 3))
            0:       return ssm_pkg::RANGE_W'($urandom);
            1:       return ssm_pkg::RANGE_W'(thr);
            2:       return (thr == RANGE_MAX) ? ssm_pkg::RANGE_W'(thr)
                                               : ssm_pkg::RANGE_W'(thr + 1);
            default: return ssm_pkg::RANGE_W'($urandom_range(0, thr));
        endcase
    endfunction

    // Confidence close to the plain, doubled, quadrupled or reactivation bar.
    function automatic logic [ssm_pkg::CONF_W-1:0] pick_conf();
        int unsigned thr;
        case ($urandom_range(0, 3))
            0:       thr = cfg.conf_min;
            1:       thr = 2 * cfg.conf_min;
            2:       thr = 4 * cfg.conf_min;
            default: thr = cfg.react_conf;
        endcase
        if (thr > 255)
            thr = 255;
        case ($urandom_range(0, 3))
            0:       return ssm_pkg::CONF_W'($urandom);
            1:       return ssm_pkg::CONF_W'(thr);
            2:       return (thr == 255) ? ssm_pkg::CONF_W'(thr) : ssm_pkg::CONF_W'(thr + 1);
            default: return ssm_pkg::CONF_W'($urandom_range(0, thr));
        endcase
    endfunction

    // Mostly running words with speed above the minimum; targets near the bars.
    function automatic ssm_pkg::t_in_item random_word();
        ssm_pkg::t_in_item w;
        int unsigned       pick, rcap;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            w.comp_state = ssm_pkg::COMP_RUN;
        else if (pick < 93)
            w.comp_state = ssm_pkg::COMP_TEMP_ERR;
        else if (pick < 97)
            w.comp_state = COMP_IDLE;
        else
            w.comp_state = COMP_UNDEF;
        if ($urandom_range(0, 6) == 0 || cfg.speed_min == '1)
            w.ego_speed = ssm_pkg::SPEED_W'($urandom);
        else
            w.ego_speed = ssm_pkg::SPEED_W'($urandom_range(int'(cfg.speed_min) + 1, 32767));
        w.bench_active = ($urandom_range(0, 24) == 0);
        if ($urandom_range(0, 2) == 0) begin
            // Targets too close for any pass criterion.
            rcap = (cfg.range_min < cfg.react_range) ? cfg.range_min : cfg.react_range;
            w.range_moving     = ssm_pkg::RANGE_W'($urandom_range(0, rcap));
            w.range_stationary = ssm_pkg::RANGE_W'($urandom_range(0, rcap));
            w.range_stat_max   = ssm_pkg::RANGE_W'($urandom_range(0, rcap));
        end else begin
            w.range_moving     = pick_range();
            w.range_stationary = pick_range();
            w.range_stat_max   = pick_range();
        end
        w.conf_moving     = pick_conf();
        w.conf_stationary = pick_conf();
        return w;
    endfunction

    function automatic ssm_pkg::t_cfg random_cfg();
        ssm_pkg::t_cfg c;
        c.selftest_enable = ($urandom_range(0, 5) != 0);
        c.speed_min       = $urandom_range(0, 3) == 0
                          ? ssm_pkg::SPDMIN_W'($urandom)
                          : ssm_pkg::SPDMIN_W'($urandom_range(0, 1500));
        c.range_min       = ssm_pkg::RANGE_W'($urandom);
        c.conf_min        = $urandom_range(0, 1) ? ssm_pkg::CONF_W'($urandom_range(0, 63))
                                                 : ssm_pkg::CONF_W'($urandom);
        c.react_range     = ssm_pkg::RANGE_W'($urandom);
        c.react_conf      = ssm_pkg::CONF_W'($urandom);
        c.time_limit_ms   = $urandom_range(0, 1)
                          ? ssm_pkg::ELAPSED_W'($urandom_range(0, 5000))
                          : ssm_pkg::ELAPSED_W'($urandom);
        c.cycle_time_ms   = ssm_pkg::CYCLE_W'($urandom);
        return c;
    endfunction

    task automatic queue_word(input ssm_pkg::t_in_item w);
        meas_pending.push_back(w);
        words_queued++;
    endtask

    task automatic write_reg(input logic [ssm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssm_pkg::CFG_DAT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
    endtask

    // Write the whole register set; only called while the block is idle.
    task automatic apply_cfg(input ssm_pkg::t_cfg c);
        write_reg(ssm_pkg::REG_SELFTEST_ENABLE, ssm_pkg::CFG_DAT_W'(c.selftest_enable));
        write_reg(ssm_pkg::REG_SPEED_MIN,       ssm_pkg::CFG_DAT_W'(c.speed_min));
        write_reg(ssm_pkg::REG_RANGE_MIN,       ssm_pkg::CFG_DAT_W'(c.range_min));
        write_reg(ssm_pkg::REG_CONF_MIN,        ssm_pkg::CFG_DAT_W'(c.conf_min));
        write_reg(ssm_pkg::REG_REACT_RANGE,     ssm_pkg::CFG_DAT_W'(c.react_range));
        write_reg(ssm_pkg::REG_REACT_CONF,      ssm_pkg::CFG_DAT_W'(c.react_conf));
        write_reg(ssm_pkg::REG_TIME_LIMIT_MS,   ssm_pkg::CFG_DAT_W'(c.time_limit_ms));
        write_reg(ssm_pkg::REG_CYCLE_TIME_MS,   ssm_pkg::CFG_DAT_W'(c.cycle_time_ms));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg = c;
        settings_used++;
    endtask

    // Wait until every queued word is taken and every status word is back.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (words_taken != words_queued || status_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        ssm_pkg::t_cfg     c;
        ssm_pkg::t_in_item w;
        int                adds;

        cfg = '{selftest_enable: 1'b1, speed_min: '0, range_min: '0, conf_min: '0,
                react_range: '0, react_conf: '0,
                time_limit_ms: ssm_pkg::TIME_LIMIT_RST,
                cycle_time_ms: ssm_pkg::CYCLE_TIME_RST};
        tst = '{cur: ssm_pkg::ST_STARTUP, last: ssm_pkg::ST_STARTUP, elapsed: '0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset settings; none of them passes startup.
        queue_word(mk(ssm_pkg::COMP_TEMP_ERR, 32767, 1, 4095, 4095, 4095, 255, 255));
        queue_word(mk(COMP_IDLE, 32767, 1, 4095, 4095, 4095, 255, 255));
        queue_word(mk(COMP_UNDEF, -32768, 0, 0, 0, 0, 0, 0));
        // Speed not above the minimum: state restored even with strong targets.
        queue_word(mk(ssm_pkg::COMP_RUN, 0, 0, 4095, 4095, 4095, 255, 255));
        queue_word(mk(ssm_pkg::COMP_RUN, -32768, 0, 4095, 4095, 4095, 255, 255));
        // Test bench forces on, then the saved startup state returns.
        queue_word(mk(ssm_pkg::COMP_RUN, 32767, 1, 0, 0, 0, 0, 0));
        queue_word(mk(ssm_pkg::COMP_RUN, -1, 1, 0, 0, 0, 0, 0));
        queue_word(mk(ssm_pkg::COMP_RUN, -1, 0, 0, 0, 0, 0, 0));
        // Failing criteria add the cycle time to the counter.
        queue_word(mk(ssm_pkg::COMP_RUN, 1, 0, 0, 0, 0, 0, 0));
        queue_word(mk(ssm_pkg::COMP_RUN, 100, 0, 4095, 0, 0, 0, 255));
        queue_word(mk(ssm_pkg::COMP_RUN, 200, 0, 0, 4095, 4095, 255, 0));
        queue_word(mk(ssm_pkg::COMP_TEMP_ERR, 0, 0, 0, 0, 0, 0, 0));
        queue_word(mk(COMP_UNDEF, 32767, 1, 4095, 4095, 4095, 255, 255));
        wait_idle();

        // Self-test disabled while still in startup.
        c = random_cfg();
        c.selftest_enable = 1'b0;
        c.range_min       = RANGE_MAX;
        c.react_range     = RANGE_MAX;
        c.time_limit_ms   = ELAPSED_MAX;
        apply_cfg(c);
        repeat (16) queue_word(random_word());
        wait_idle();

        // Startup cannot pass: run the counter into saturation; most words add time.
        c.selftest_enable = 1'b1;
        c.cycle_time_ms   = '1;
        c.speed_min       = ssm_pkg::SPDMIN_W'($urandom_range(0, 2000));
        apply_cfg(c);
        adds = 0;
        while (adds < 1030) begin
            w = random_word();
            if ($urandom_range(0, 39) != 0) begin
                w.comp_state   = ssm_pkg::COMP_RUN;
                w.bench_active = 1'b0;
                w.ego_speed    = ssm_pkg::SPEED_W'($urandom_range(
                                     int'(cfg.speed_min) + 1, 32767));
            end
            queue_word(w);
            if (w.comp_state == ssm_pkg::COMP_RUN && !w.bench_active
                    && int'($signed(w.ego_speed)) > int'(cfg.speed_min))
                adds++;
        end
        wait_idle();

        // Leave startup either through the pass criteria or through the time limit.
        exit_by_pass = $urandom_range(0, 1);
        c = random_cfg();
        c.selftest_enable = 1'b1;
        c.speed_min       = ssm_pkg::SPDMIN_W'($urandom_range(0, 2000));
        c.time_limit_ms   = exit_by_pass
                          ? ELAPSED_MAX
                          : ssm_pkg::ELAPSED_W'($urandom_range(0, ELAPSED_MAX - 1));
        apply_cfg(c);
        if (!exit_by_pass) begin
            w = random_word();
            w.comp_state       = ssm_pkg::COMP_RUN;
            w.bench_active     = 1'b0;
            w.ego_speed        = ssm_pkg::SPEED_W'(c.speed_min + 1);
            w.range_moving     = '0;
            w.range_stationary = '0;
            w.range_stat_max   = '0;
            queue_word(w);
        end
        repeat (30) queue_word(random_word());
        wait_idle();

        // Extreme settings, then random ones.
        for (int p = 0; p < 5; p++) begin
            if (p == 0)
                c = '0;
            else if (p == 1)
                c = '1;
            else
                c = random_cfg();
            apply_cfg(c);
            repeat (12) queue_word(random_word());
            wait_idle();
        end

        $display("Checked %0d status words for %0d measurement words under %0d settings.",
                 results_seen, words_taken, settings_used);
        $display("Startup ended by %s; final state %0d, counter %0d ms.",
                 exit_by_pass ? "pass criteria" : "time limit", tst.cur, tst.elapsed);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ssm_pkg.sv
rtl/ssm_eval.sv
rtl/sensor_selftest_monitor_core.sv
test/tb_sensor_selftest_monitor_core.sv
